// ===== sv/sfr_pkg.sv =====
// shared types, constants and the crc step for the serial frame receiver
package sfr_pkg;

    // frame geometry
    localparam int PAYLOAD_LEN = 59;
    localparam int ADDR_W      = (PAYLOAD_LEN > 1) ? $clog2(PAYLOAD_LEN) : 1;
    localparam int POS_W       = 7;
    localparam int IDX_W       = 6;
    localparam int CNT_W       = 32;

    localparam logic [POS_W-1:0] POS_LEN    = POS_W'(1);
    localparam logic [POS_W-1:0] POS_DATA0  = POS_W'(2);
    localparam logic [POS_W-1:0] POS_CRC_LO = POS_W'(PAYLOAD_LEN + 2);
    localparam logic [POS_W-1:0] POS_CRC_HI = POS_W'(PAYLOAD_LEN + 3);
    localparam logic [POS_W-1:0] POS_TAIL   = POS_W'(PAYLOAD_LEN + 4);
    localparam logic [7:0]       LEN_BYTE   = 8'(PAYLOAD_LEN);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PAYLOAD_LEN - 1);

    // crc-16, polynomial 0x8005, msb first
    localparam logic [15:0] CRC_POLY = 16'h8005;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // register map, decoded on paddr[2]
    localparam int  PADDR_W  = 3;
    localparam logic REG_HEAD = 1'b0;
    localparam logic REG_TAIL = 1'b1;
    localparam logic [7:0] HEAD_RESET = 8'hAA;
    localparam logic [7:0] TAIL_RESET = 8'h55;

    // result status codes
    localparam logic [1:0] STATUS_GOOD    = 2'd0;
    localparam logic [1:0] STATUS_REJECT  = 2'd1;
    localparam logic [1:0] STATUS_TIMEOUT = 2'd2;

    localparam logic KIND_BYTE    = 1'b0;
    localparam logic KIND_TIMEOUT = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [7:0]       payload_byte;
        logic [IDX_W-1:0] byte_index;
        logic             last;
        logic [CNT_W-1:0] frames_passed;
        logic [CNT_W-1:0] frames_rejected;
        logic [CNT_W-1:0] timeouts;
    } out_item_t;

    typedef enum logic [1:0] {
        S_RUN,
        S_READ,
        S_LOAD
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic take;
        logic rd_issue;
        logic out_load;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic would_emit;
        logic good_frame;
        logic out_full;
        logic rd_last;
    } dp_status_t;

    // one byte of crc, bit by bit
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== sv/serial_frame_receiver_crc16.sv =====
// top level: register port, controller and datapath of the serial frame receiver
// a timeout or reject result is registered and shows in the cycle after its input beat
// throughput: one input beat per cycle while a frame is received, but a timeout or
// tail beat is held while the output register is full; a good frame then drains its
// 59 payload beats, each by a buffer read and a load, and takes no input meanwhile
// reset (rst_n, async, active low): hunting, counters zero, markers 0xAA and 0x55
module serial_frame_receiver_crc16 (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sfr_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  sfr_pkg::in_item_t            in_data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output sfr_pkg::out_item_t           out_data
);

    logic [7:0]          head_reg;
    logic [7:0]          tail_reg;
    logic                wr_en;
    sfr_pkg::dp_cmd_t    cmd;
    sfr_pkg::dp_status_t sts;

    // register port
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= sfr_pkg::HEAD_RESET;
            tail_reg <= sfr_pkg::TAIL_RESET;
        end
        else if (wr_en)
        begin
            if (paddr[2] == sfr_pkg::REG_HEAD)
            begin
                head_reg <= pwdata[7:0];
            end
            else
            begin
                tail_reg <= pwdata[7:0];
            end
        end
    end

    assign prdata = (paddr[2] == sfr_pkg::REG_TAIL) ? {24'h0, tail_reg} : {24'h0, head_reg};

    // controller
    sfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .sts      (sts),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    // datapath
    sfr_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_marker (head_reg),
        .tail_marker (tail_reg),
        .in_data     (in_data),
        .cmd         (cmd),
        .out_stall   (out_stall),
        .sts         (sts),
        .out_valid   (out_valid),
        .out_data    (out_data)
    );

endmodule

// ===== sv/sfr_ctrl.sv =====
// controller: input acceptance and payload drain sequencing
module sfr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  sfr_pkg::dp_status_t sts,
    output logic                in_stall,
    output sfr_pkg::dp_cmd_t    cmd
);

    sfr_pkg::state_t state_reg;
    sfr_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sfr_pkg::S_RUN;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sfr_pkg::S_RUN:
            begin
                if (cmd.take && sts.good_frame)
                begin
                    state_next = sfr_pkg::S_READ;
                end
            end
            sfr_pkg::S_READ:
            begin
                state_next = sfr_pkg::S_LOAD;
            end
            sfr_pkg::S_LOAD:
            begin
                if (!sts.out_full)
                begin
                    state_next = sts.rd_last ? sfr_pkg::S_RUN : sfr_pkg::S_READ;
                end
            end
            default:
            begin
                state_next = sfr_pkg::S_RUN;
            end
        endcase
    end

    // outputs: a beat that would produce a result waits for a free output slot
    always_comb
    begin
        in_stall     = 1'b1;
        cmd.take     = 1'b0;
        cmd.rd_issue = 1'b0;
        cmd.out_load = 1'b0;
        case (state_reg)
            sfr_pkg::S_RUN:
            begin
                in_stall = sts.out_full && sts.would_emit;
                cmd.take = in_valid && !in_stall;
            end
            sfr_pkg::S_READ:
            begin
                cmd.rd_issue = 1'b1;
            end
            sfr_pkg::S_LOAD:
            begin
                cmd.out_load = !sts.out_full;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

// ===== sv/sfr_dpath.sv =====
// datapath: frame tracking, crc, payload buffer, counters and output register
module sfr_dpath (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          head_marker,
    input  logic [7:0]          tail_marker,
    input  sfr_pkg::in_item_t   in_data,
    input  sfr_pkg::dp_cmd_t    cmd,
    input  logic                out_stall,
    output sfr_pkg::dp_status_t sts,
    output logic                out_valid,
    output sfr_pkg::out_item_t  out_data
);

    logic                           in_frame_reg, in_frame_next;
    logic [sfr_pkg::POS_W-1:0]      pos_reg, pos_next;
    logic                           len_ok_reg, len_ok_next;
    logic [15:0]                    crc_reg, crc_next;
    logic [7:0]                     crc_lo_reg, crc_lo_next;
    logic [7:0]                     crc_hi_reg, crc_hi_next;
    logic [sfr_pkg::CNT_W-1:0]      good_reg, good_next;
    logic [sfr_pkg::CNT_W-1:0]      bad_reg, bad_next;
    logic [sfr_pkg::CNT_W-1:0]      tmo_reg, tmo_next;
    logic [sfr_pkg::ADDR_W-1:0]     rd_idx_reg, rd_idx_next;
    logic                           out_valid_reg, out_valid_next;
    logic [1:0]                     status_reg, status_next;
    logic [7:0]                     pbyte_reg, pbyte_next;
    logic [sfr_pkg::IDX_W-1:0]      idx_reg, idx_next;
    logic                           last_reg, last_next;

    logic [7:0]                     mem [sfr_pkg::PAYLOAD_LEN];
    logic [7:0]                     rdata_reg;
    logic                           mem_we;
    logic [sfr_pkg::ADDR_W-1:0]     wr_addr;

    logic                           at_tail;
    logic                           is_byte;
    logic                           frame_ok;
    logic                           in_payload;

    // frame status
    assign is_byte    = (in_data.kind == sfr_pkg::KIND_BYTE);
    assign at_tail    = in_frame_reg && (pos_reg == sfr_pkg::POS_TAIL);
    assign in_payload = in_frame_reg && (pos_reg >= sfr_pkg::POS_DATA0)
                        && (pos_reg < sfr_pkg::POS_CRC_LO);
    assign frame_ok   = len_ok_reg && (in_data.rx_byte == tail_marker)
                        && ({crc_hi_reg, crc_lo_reg} == crc_reg);
    assign wr_addr    = sfr_pkg::ADDR_W'(pos_reg - sfr_pkg::POS_DATA0);
    assign mem_we     = cmd.take && is_byte && in_payload;

    assign sts.would_emit = !is_byte || at_tail;
    assign sts.good_frame = is_byte && at_tail && frame_ok;
    assign sts.out_full   = out_valid_reg && out_stall;
    assign sts.rd_last    = (rd_idx_reg == sfr_pkg::LAST_ADDR);

    // frame parsing and counters
    always_comb
    begin
        in_frame_next = in_frame_reg;
        pos_next      = pos_reg;
        len_ok_next   = len_ok_reg;
        crc_next      = crc_reg;
        crc_lo_next   = crc_lo_reg;
        crc_hi_next   = crc_hi_reg;
        good_next     = good_reg;
        bad_next      = bad_reg;
        tmo_next      = tmo_reg;
        rd_idx_next   = rd_idx_reg;
        status_next   = status_reg;
        pbyte_next    = pbyte_reg;
        idx_next      = idx_reg;
        last_next     = last_reg;
        out_valid_next = out_valid_reg && out_stall;

        if (cmd.take)
        begin
            if (!is_byte)
            begin
                // timeout: drop the frame and report
                in_frame_next  = 1'b0;
                pos_next       = '0;
                len_ok_next    = 1'b0;
                crc_next       = sfr_pkg::CRC_INIT;
                tmo_next       = (tmo_reg == sfr_pkg::CNT_MAX) ? tmo_reg
                                 : tmo_reg + sfr_pkg::CNT_W'(1);
                out_valid_next = 1'b1;
                status_next    = sfr_pkg::STATUS_TIMEOUT;
                pbyte_next     = '0;
                idx_next       = '0;
                last_next      = 1'b1;
            end
            else if (!in_frame_reg)
            begin
                // hunting for the head byte
                if (in_data.rx_byte == head_marker)
                begin
                    in_frame_next = 1'b1;
                    pos_next      = sfr_pkg::POS_LEN;
                    len_ok_next   = 1'b0;
                    crc_next      = sfr_pkg::CRC_INIT;
                end
            end
            else if (at_tail)
            begin
                // judge the frame
                in_frame_next = 1'b0;
                pos_next      = '0;
                len_ok_next   = 1'b0;
                crc_next      = sfr_pkg::CRC_INIT;
                rd_idx_next   = '0;
                if (frame_ok)
                begin
                    good_next = (good_reg == sfr_pkg::CNT_MAX) ? good_reg
                                : good_reg + sfr_pkg::CNT_W'(1);
                end
                else
                begin
                    bad_next       = (bad_reg == sfr_pkg::CNT_MAX) ? bad_reg
                                     : bad_reg + sfr_pkg::CNT_W'(1);
                    out_valid_next = 1'b1;
                    status_next    = sfr_pkg::STATUS_REJECT;
                    pbyte_next     = '0;
                    idx_next       = '0;
                    last_next      = 1'b1;
                end
            end
            else
            begin
                if (pos_reg == sfr_pkg::POS_LEN)
                begin
                    len_ok_next = (in_data.rx_byte == sfr_pkg::LEN_BYTE);
                end
                else if (in_payload)
                begin
                    crc_next = sfr_pkg::crc16_byte(crc_reg, in_data.rx_byte);
                end
                else if (pos_reg == sfr_pkg::POS_CRC_LO)
                begin
                    crc_lo_next = in_data.rx_byte;
                end
                else if (pos_reg == sfr_pkg::POS_CRC_HI)
                begin
                    crc_hi_next = in_data.rx_byte;
                end
                pos_next = pos_reg + sfr_pkg::POS_W'(1);
            end
        end

        // payload drain beat
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
            status_next    = sfr_pkg::STATUS_GOOD;
            pbyte_next     = rdata_reg;
            idx_next       = sfr_pkg::IDX_W'(rd_idx_reg);
            last_next      = sts.rd_last;
            rd_idx_next    = rd_idx_reg + sfr_pkg::ADDR_W'(1);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg  <= 1'b0;
            pos_reg       <= '0;
            len_ok_reg    <= 1'b0;
            crc_reg       <= sfr_pkg::CRC_INIT;
            crc_lo_reg    <= '0;
            crc_hi_reg    <= '0;
            good_reg      <= '0;
            bad_reg       <= '0;
            tmo_reg       <= '0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_frame_reg  <= in_frame_next;
            pos_reg       <= pos_next;
            len_ok_reg    <= len_ok_next;
            crc_reg       <= crc_next;
            crc_lo_reg    <= crc_lo_next;
            crc_hi_reg    <= crc_hi_next;
            good_reg      <= good_next;
            bad_reg       <= bad_next;
            tmo_reg       <= tmo_next;
            rd_idx_reg    <= rd_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload registers
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        pbyte_reg  <= pbyte_next;
        idx_reg    <= idx_next;
        last_reg   <= last_next;
    end

    // payload buffer write port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= in_data.rx_byte;
        end
    end

    // payload buffer read port
    always_ff @(posedge clk)
    begin
        if (cmd.rd_issue)
        begin
            rdata_reg <= mem[rd_idx_reg];
        end
    end

    // result beat; counters stay put while a result waits
    assign out_valid                = out_valid_reg;
    assign out_data.status          = status_reg;
    assign out_data.payload_byte    = pbyte_reg;
    assign out_data.byte_index      = idx_reg;
    assign out_data.last            = last_reg;
    assign out_data.frames_passed   = good_reg;
    assign out_data.frames_rejected = bad_reg;
    assign out_data.timeouts        = tmo_reg;

endmodule

// ===== tb/serial_frame_receiver_crc16_test.sv =====
// self-checking testbench for the serial frame receiver with crc-16 check
`timescale 1ns / 1ps

module serial_frame_receiver_crc16_test;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int SETTLE_QUIET    = 8;
    localparam int END_QUIET       = 24;
    localparam int PHASES          = 5;
    localparam int BEATS_PER_PHASE = 84;

    typedef enum int {FLAW_NONE, FLAW_CRC, FLAW_LEN, FLAW_TAIL, FLAW_CUT} flaw_t;
    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_PERIODIC, STALL_HEAVY} stall_mode_t;

    // block ports
    logic                        clk     = 1'b0;
    logic                        rst_n   = 1'b0;
    logic                        psel    = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite  = 1'b0;
    logic [sfr_pkg::PADDR_W-1:0] paddr   = '0;
    logic [31:0]                 pwdata  = '0;
    logic [31:0]                 prdata;
    logic                        pready;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    sfr_pkg::in_item_t           in_data  = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    sfr_pkg::out_item_t          out_data;

    serial_frame_receiver_crc16 DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // predictor state, mirrors the block
    logic [7:0]                head_reg = sfr_pkg::HEAD_RESET;
    logic [7:0]                tail_reg = sfr_pkg::TAIL_RESET;
    logic                      fr_open  = 1'b0;
    logic [sfr_pkg::POS_W-1:0] fr_pos   = '0;
    logic                      len_ok   = 1'b0;
    logic [15:0]               crc_acc  = sfr_pkg::CRC_INIT;
    logic [7:0]                crc_lo   = '0;
    logic [7:0]                crc_hi   = '0;
    logic [7:0]                payload_mem [sfr_pkg::PAYLOAD_LEN];
    logic [sfr_pkg::CNT_W-1:0] good_frames     = '0;
    logic [sfr_pkg::CNT_W-1:0] rejected_frames = '0;
    logic [sfr_pkg::CNT_W-1:0] timeout_events  = '0;
    sfr_pkg::out_item_t        pending_results [$];

    // stimulus side
    sfr_pkg::in_item_t pending_beats [$];
    sfr_pkg::in_item_t frame_beats [$];
    logic [7:0]        gen_head = sfr_pkg::HEAD_RESET;
    logic [7:0]        gen_tail = sfr_pkg::TAIL_RESET;
    int                item_count = 0;
    int                seq_no     = 0;

    // bookkeeping
    int                 fail_count   = 0;
    int                 results_seen = 0;
    int                 beats_taken  = 0;
    int                 cycle_count  = 0;
    int                 burst_left   = 0;
    int                 gap_left     = 0;
    stall_mode_t        stall_mode   = STALL_NONE;
    int                 mode_left    = 0;
    int                 stall_phase  = 0;
    sfr_pkg::out_item_t want;

    initial
    begin
        forever #5 clk = ~clk;
    end

    // crc-16, polynomial 0x8005, one data bit at a time, msb first
    function automatic logic [15:0] crc_next(input logic [15:0] acc, input logic [7:0] data);
        logic [15:0] r;
        r = acc;
        for (int k = 7; k >= 0; k--)
        begin
            if (r[15] ^ data[k])
                r = {r[14:0], 1'b0} ^ sfr_pkg::CRC_POLY;
            else
                r = {r[14:0], 1'b0};
        end
        return r;
    endfunction

    function automatic sfr_pkg::out_item_t make_result(input logic [1:0] st,
                                                       input logic [7:0] pb,
                                                       input logic [sfr_pkg::IDX_W-1:0] idx,
                                                       input logic fin);
        sfr_pkg::out_item_t r;
        r.status          = st;
        r.payload_byte    = pb;
        r.byte_index      = idx;
        r.last            = fin;
        r.frames_passed   = good_frames;
        r.frames_rejected = rejected_frames;
        r.timeouts        = timeout_events;
        return r;
    endfunction

    task automatic close_frame();
        fr_open = 1'b0;
        fr_pos  = '0;
        len_ok  = 1'b0;
        crc_acc = sfr_pkg::CRC_INIT;
    endtask

    // expected results of one accepted input beat
    task automatic predict_beat(input sfr_pkg::in_item_t beat);
        logic [15:0] rx_crc;
        if (beat.kind == sfr_pkg::KIND_TIMEOUT)
        begin
            close_frame();
            if (timeout_events != sfr_pkg::CNT_MAX)
                timeout_events++;
            pending_results.push_back(make_result(sfr_pkg::STATUS_TIMEOUT, 8'h00, '0, 1'b1));
        end
        else if (!fr_open)
        begin
            if (beat.rx_byte == head_reg)
            begin
                close_frame();
                fr_open = 1'b1;
                fr_pos  = sfr_pkg::POS_LEN;
            end
        end
        else if (fr_pos == sfr_pkg::POS_TAIL)
        begin
            // judge the frame on length, tail and crc
            rx_crc = {crc_hi, crc_lo};
            if (len_ok && beat.rx_byte == tail_reg && rx_crc == crc_acc)
            begin
                if (good_frames != sfr_pkg::CNT_MAX)
                    good_frames++;
                for (int k = 0; k < sfr_pkg::PAYLOAD_LEN; k++)
                    pending_results.push_back(make_result(sfr_pkg::STATUS_GOOD,
                                                          payload_mem[k],
                                                          sfr_pkg::IDX_W'(k),
                                                          k == sfr_pkg::PAYLOAD_LEN - 1));
            end
            else
            begin
                if (rejected_frames != sfr_pkg::CNT_MAX)
                    rejected_frames++;
                pending_results.push_back(make_result(sfr_pkg::STATUS_REJECT, 8'h00, '0,
                                                      1'b1));
            end
            close_frame();
        end
        else
        begin
            if (fr_pos == sfr_pkg::POS_LEN)
                len_ok = (beat.rx_byte == sfr_pkg::LEN_BYTE);
            else if (fr_pos < sfr_pkg::POS_CRC_LO)
            begin
                payload_mem[fr_pos - sfr_pkg::POS_DATA0] = beat.rx_byte;
                crc_acc = crc_next(crc_acc, beat.rx_byte);
            end
            else if (fr_pos == sfr_pkg::POS_CRC_LO)
                crc_lo = beat.rx_byte;
            else
                crc_hi = beat.rx_byte;
            fr_pos++;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // monitor: register writes, accepted input beats, then result beats
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == sfr_pkg::REG_HEAD)
                    head_reg = pwdata[7:0];
                else
                    tail_reg = pwdata[7:0];
            end
            if (in_valid && !in_stall)
            begin
                predict_beat(in_data);
                beats_taken++;
            end
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result beat, expected none, actual %p",
                             $time, out_data);
                    fail_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("status", want.status, out_data.status);
                    check_field("payload_byte", want.payload_byte, out_data.payload_byte);
                    check_field("byte_index", want.byte_index, out_data.byte_index);
                    check_field("last", want.last, out_data.last);
                    check_field("frames_passed", want.frames_passed,
                                out_data.frames_passed);
                    check_field("frames_rejected", want.frames_rejected,
                                out_data.frames_rejected);
                    check_field("timeouts", want.timeouts, out_data.timeouts);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // driver: bursts of beats from the pending queue with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            in_data    <= '0;
            burst_left = $urandom_range(1, 40);
            gap_left   = 0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_beats.size() > 0)
            begin
                in_data  <= pending_beats.pop_front();
                in_valid <= 1'b1;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 80);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result side stall, switching between patterns
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            mode_left = 0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = stall_mode_t'($urandom_range(0, 3));
                mode_left  = $urandom_range(20, 200);
            end
            mode_left--;
            stall_phase++;
            case (stall_mode)
                STALL_NONE:     out_stall <= 1'b0;
                STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
                STALL_PERIODIC: out_stall <= (stall_phase % 3 == 0);
                default:        out_stall <= ($urandom_range(0, 1) == 1);
            endcase
        end
    end

    task automatic send_beat(input logic k, input logic [7:0] b);
        sfr_pkg::in_item_t beat;
        beat.kind    = k;
        beat.rx_byte = b;
        pending_beats.push_back(beat);
        item_count++;
    endtask

    task automatic stage_beat(input logic k, input logic [7:0] b);
        sfr_pkg::in_item_t beat;
        beat.kind    = k;
        beat.rx_byte = b;
        frame_beats.push_back(beat);
    endtask

    // move staged frame beats to the driver
    task automatic release_beats(input int n);
        for (int k = 0; k < n && frame_beats.size() > 0; k++)
        begin
            pending_beats.push_back(frame_beats.pop_front());
            item_count++;
        end
    endtask

    // stage one frame, correct or with the given flaw
    task automatic build_frame(input flaw_t flaw, input logic [7:0] hd, input logic [7:0] tl);
        logic [7:0]  body [sfr_pkg::PAYLOAD_LEN];
        logic [15:0] sum;
        logic [7:0]  len_b;
        logic [7:0]  tail_b;
        int          cut;
        sum = sfr_pkg::CRC_INIT;
        for (int k = 0; k < sfr_pkg::PAYLOAD_LEN; k++)
        begin
            case ($urandom_range(0, 9))
                0:       body[k] = hd;
                1:       body[k] = 8'h00;
                2:       body[k] = 8'hFF;
                default: body[k] = 8'($urandom);
            endcase
            sum = crc_next(sum, body[k]);
        end
        if (flaw == FLAW_CRC)
            sum = sum ^ 16'($urandom_range(1, 16'hFFFF));
        len_b = sfr_pkg::LEN_BYTE;
        if (flaw == FLAW_LEN)
            while (len_b == sfr_pkg::LEN_BYTE)
                len_b = 8'($urandom);
        tail_b = tl;
        if (flaw == FLAW_TAIL)
            while (tail_b == tl)
                tail_b = 8'($urandom);
        stage_beat(sfr_pkg::KIND_BYTE, hd);
        stage_beat(sfr_pkg::KIND_BYTE, len_b);
        for (int k = 0; k < sfr_pkg::PAYLOAD_LEN; k++)
            stage_beat(sfr_pkg::KIND_BYTE, body[k]);
        stage_beat(sfr_pkg::KIND_BYTE, sum[7:0]);
        stage_beat(sfr_pkg::KIND_BYTE, sum[15:8]);
        stage_beat(sfr_pkg::KIND_BYTE, tail_b);
        // partial frame dropped by a timeout
        if (flaw == FLAW_CUT)
        begin
            cut = $urandom_range(0, sfr_pkg::PAYLOAD_LEN + 3);
            while (frame_beats.size() > cut + 1)
                void'(frame_beats.pop_back());
            stage_beat(sfr_pkg::KIND_TIMEOUT, 8'($urandom));
        end
    endtask

    // junk between frames, mostly clear of the head marker
    task automatic add_noise();
        logic [7:0]        b;
        sfr_pkg::in_item_t beat;
        repeat ($urandom_range(1, 4))
        begin
            b = 8'($urandom);
            if (b == gen_head && $urandom_range(0, 7) != 0)
                b = b ^ 8'h01;
            beat.kind    = ($urandom_range(0, 15) == 0) ? sfr_pkg::KIND_TIMEOUT
                           : sfr_pkg::KIND_BYTE;
            beat.rx_byte = b;
            pending_beats.push_back(beat);
        end
    endtask

    task automatic write_reg(input logic sel, input logic [7:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= {24'h0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // idle once nothing is pending or expected for some cycles in a row
    task automatic wait_idle(input int quiet_needed);
        int quiet;
        quiet = 0;
        while (quiet < quiet_needed)
        begin
            @(posedge clk);
            if (pending_beats.size() == 0 && !in_valid && pending_results.size() == 0)
                quiet++;
            else
                quiet = 0;
        end
    endtask

    initial
    begin
        logic [7:0] next_head;
        logic [7:0] next_tail;
        flaw_t      flaw;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: hunting, timeouts, head-valued frame bytes, early drops
        send_beat(sfr_pkg::KIND_BYTE, 8'h00);
        send_beat(sfr_pkg::KIND_BYTE, 8'hFF);
        send_beat(sfr_pkg::KIND_BYTE, sfr_pkg::TAIL_RESET);
        send_beat(sfr_pkg::KIND_TIMEOUT, 8'h00);
        send_beat(sfr_pkg::KIND_TIMEOUT, 8'hFF);
        send_beat(sfr_pkg::KIND_BYTE, sfr_pkg::HEAD_RESET);
        send_beat(sfr_pkg::KIND_BYTE, sfr_pkg::HEAD_RESET);
        send_beat(sfr_pkg::KIND_BYTE, sfr_pkg::LEN_BYTE);
        send_beat(sfr_pkg::KIND_BYTE, 8'h00);
        send_beat(sfr_pkg::KIND_BYTE, 8'hFF);
        send_beat(sfr_pkg::KIND_TIMEOUT, 8'h5A);
        send_beat(sfr_pkg::KIND_BYTE, sfr_pkg::HEAD_RESET);
        send_beat(sfr_pkg::KIND_TIMEOUT, 8'hA5);
        send_beat(sfr_pkg::KIND_BYTE, 8'h01);
        wait_idle(SETTLE_QUIET);
        item_count = 0;

        for (int p = 0; p < PHASES; p++)
        begin
            // new marker setting, changed in the middle of a frame
            if (p > 0)
            begin
                case (p)
                    1:       begin next_head = 8'h00; next_tail = 8'hFF; end
                    2:       begin next_head = 8'hFF; next_tail = 8'h00; end
                    3:       begin next_head = 8'h7E; next_tail = 8'h7E; end
                    default: begin next_head = 8'($urandom); next_tail = 8'($urandom); end
                endcase
                build_frame(FLAW_NONE, gen_head, next_tail);
                release_beats($urandom_range(2, sfr_pkg::PAYLOAD_LEN + 2));
                wait_idle(SETTLE_QUIET);
                write_reg(sfr_pkg::REG_HEAD, next_head);
                write_reg(sfr_pkg::REG_TAIL, next_tail);
                gen_head = next_head;
                gen_tail = next_tail;
                release_beats(frame_beats.size());
            end

            // frames with random content, some of them broken
            while (item_count < (p + 1) * BEATS_PER_PHASE)
            begin
                if ($urandom_range(0, 1) == 1)
                    add_noise();
                case (seq_no % 8)
                    1:       flaw = FLAW_CRC;
                    3:       flaw = FLAW_LEN;
                    5:       flaw = FLAW_TAIL;
                    7:       flaw = FLAW_CUT;
                    default: flaw = FLAW_NONE;
                endcase
                seq_no++;
                build_frame(flaw, gen_head, gen_tail);
                release_beats(frame_beats.size());
            end
            wait_idle(SETTLE_QUIET);
        end

        wait_idle(END_QUIET);
        $display("%0d input beats over %0d marker settings, %0d result beats checked",
                 beats_taken, PHASES, results_seen);
        $display("frames passed %0d, rejected %0d, timeouts %0d",
                 good_frames, rejected_frames, timeout_events);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/sfr_pkg.sv
sv/sfr_ctrl.sv
sv/sfr_dpath.sv
sv/serial_frame_receiver_crc16.sv
tb/serial_frame_receiver_crc16_test.sv
